// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication or plain property, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/md5_pkg.sv -----
// Shared types, constants and helper functions of the MD5 digest core.
package md5_pkg;

    // Working or chaining state of the compression function.
    typedef struct packed {
        logic [31:0] d;
        logic [31:0] c;
        logic [31:0] b;
        logic [31:0] a;
    } md5_state_t;

    // Write controls from the sequencer to the block buffer.
    typedef struct packed {
        logic byte_wr;
        logic clear;
        logic pad;
        logic len_wr;
    } buf_ctrl_t;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_RND = 6'd63;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Rotate a 32-bit word left by a 5-bit amount.
    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

    // Standard initial chaining value.
    function automatic md5_state_t init_chain();
        md5_state_t st;
        st.a = INIT_A;
        st.b = INIT_B;
        st.c = INIT_C;
        st.d = INIT_D;
        return st;
    endfunction

endpackage

// ----- src/md5_blk_buf.sv -----
// Sixteen-word message block buffer with byte writes, padding and length fill.
module md5_blk_buf
    import md5_pkg::*;
(
    input  logic        clk,
    input  buf_ctrl_t   ctrl,
    input  logic [5:0]  pos,
    input  logic [7:0]  data_byte,
    input  logic [63:0] length,
    input  logic [3:0]  rd_idx,
    output logic [31:0] rd_word
);

    logic [31:0] blk_reg  [16];
    logic [31:0] blk_next [16];

    // Apply clear, byte write, padding and length in that order.
    always_comb
    begin
        blk_next = blk_reg;
        if (ctrl.clear)
        begin
            for (int w = 0; w < 16; w++)
            begin
                blk_next[w] = '0;
            end
        end
        if (ctrl.byte_wr)
        begin
            blk_next[pos[5:2]][8*pos[1:0] +: 8] = data_byte;
        end
        if (ctrl.pad)
        begin
            for (int w = 0; w < 16; w++)
            begin
                for (int l = 0; l < 4; l++)
                begin
                    if (6'(w * 4 + l) == pos)
                    begin
                        blk_next[w][8*l +: 8] = PAD_BYTE;
                    end
                    else if (6'(w * 4 + l) > pos)
                    begin
                        blk_next[w][8*l +: 8] = 8'h00;
                    end
                end
            end
        end
        if (ctrl.len_wr)
        begin
            blk_next[14] = length[31:0];
            blk_next[15] = length[63:32];
        end
    end

    // Buffer words hold payload only and need no reset.
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

    assign rd_word = blk_reg[rd_idx];

endmodule

// ----- src/md5_round.sv -----
// Shared MD5 round unit: working registers and one round of logic per cycle while step is high.
module md5_round
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  logic        step,
    input  md5_state_t  init,
    input  logic [5:0]  rnd,
    input  logic [31:0] msg_word,
    output logic [3:0]  msg_idx,
    output md5_state_t  work
);

    md5_state_t  work_reg;
    md5_state_t  work_next;
    logic [31:0] f;
    logic [3:0]  t;
    logic [31:0] sum;
    logic [4:0]  s;

    assign t = rnd[3:0];

    // Round function and message word index per group of sixteen rounds.
    always_comb
    begin
        unique case (rnd[5:4])
            2'd0:
            begin
                f       = (work_reg.b & work_reg.c) | (~work_reg.b & work_reg.d);
                msg_idx = t;
            end
            2'd1:
            begin
                f       = (work_reg.b & work_reg.d) | (work_reg.c & ~work_reg.d);
                msg_idx = 4'(t * 4'd5 + 4'd1);
            end
            2'd2:
            begin
                f       = work_reg.b ^ work_reg.c ^ work_reg.d;
                msg_idx = 4'(t * 4'd3 + 4'd5);
            end
            default:
            begin
                f       = work_reg.c ^ (work_reg.b | ~work_reg.d);
                msg_idx = 4'(t * 4'd7);
            end
        endcase
    end

    // One round: add, rotate, add, then shift the word roles.
    always_comb
    begin
        s           = ROT_S[{rnd[5:4], rnd[1:0]}];
        sum         = work_reg.a + f + ROUND_K[rnd] + msg_word;
        work_next.a = work_reg.d;
        work_next.d = work_reg.c;
        work_next.c = work_reg.b;
        work_next.b = work_reg.b + rotl32(sum, s);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            work_reg <= init;
        end
        else if (step)
        begin
            work_reg <= work_next;
        end
    end

    assign work = work_reg;

endmodule

// ----- src/md5_message_digest_core.sv -----
// MD5 digest core: sequencer, chaining state and bit count around the round unit.
//
// Input channel s_*: one word per message byte. s_tdata[7:0] is the byte,
// s_tuser says the byte is present (0 only on an empty final word), and
// s_tlast ends the message. Output channel m_*: two words per message, the
// digest as two 64-bit halves (m_tuser is the half index, m_tlast marks the
// second half), digest byte 0 in the low bits of the first half.
// A byte that does not complete a 64-byte block is taken while idle, one
// per cycle. The byte that completes a block starts 64 rounds on the shared
// round unit, then the result is folded into the chaining state and the
// core returns to idle. A last word adds one or two final blocks, each of
// which loads the padding or the length, runs 64 rounds and the fold.
// The first half is shown after the last of these blocks. The round
// unit does one round per cycle.
// s_tready is low while a block is compressed and while the digest is
// offered. When the receiver stalls, the digest half holds on m_tdata until
// taken. After the second half is taken the chaining state and the bit count
// return to their initial values. Reset (rst_n low) loads the initial state
// and leaves the block idle and ready.
module md5_message_digest_core
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] digest_half
    output logic        m_tuser,   // [0] half_index
    output logic        m_tlast
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FOLD  = 3'd3;
    localparam logic [2:0] ST_LEN   = 3'd4;
    localparam logic [2:0] ST_OUT0  = 3'd5;
    localparam logic [2:0] ST_OUT1  = 3'd6;

    // What follows the compression in progress.
    localparam logic [1:0] PH_DATA = 2'd0;
    localparam logic [1:0] PH_SPILL = 2'd1;
    localparam logic [1:0] PH_FINAL = 2'd2;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic        last_reg, last_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [63:0] count_reg, count_next;
    md5_state_t  chain_reg, chain_next;

    buf_ctrl_t   bctl;
    logic        load;
    logic        step;
    logic        s_acc;
    logic [5:0]  pos;
    logic [3:0]  msg_idx;
    logic [31:0] msg_word;
    md5_state_t  work;

    assign s_acc = s_tvalid && s_tready;
    assign pos   = count_reg[8:3];

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        last_next  = last_reg;
        rnd_next   = rnd_reg;
        count_next = count_reg;
        chain_next = chain_reg;
        bctl       = '0;
        load       = 1'b0;
        step       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    last_next = s_tlast;
                    if (s_tuser)
                    begin
                        bctl.byte_wr = 1'b1;
                        count_next   = count_reg + 64'd8;
                    end
                    if (s_tuser && pos == LAST_POS)
                    begin
                        load       = 1'b1;
                        rnd_next   = '0;
                        phase_next = PH_DATA;
                        state_next = ST_ROUND;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                bctl.pad = 1'b1;
                load     = 1'b1;
                rnd_next = '0;
                if (pos >= LEN_POS)
                begin
                    phase_next = PH_SPILL;
                end
                else
                begin
                    bctl.len_wr = 1'b1;
                    phase_next  = PH_FINAL;
                end
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                step     = 1'b1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == LAST_RND)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                chain_next.a = chain_reg.a + work.a;
                chain_next.b = chain_reg.b + work.b;
                chain_next.c = chain_reg.c + work.c;
                chain_next.d = chain_reg.d + work.d;
                if (phase_reg == PH_FINAL)
                begin
                    state_next = ST_OUT0;
                end
                else if (phase_reg == PH_SPILL)
                begin
                    state_next = ST_LEN;
                end
                else if (last_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LEN:
            begin
                bctl.clear  = 1'b1;
                bctl.len_wr = 1'b1;
                load        = 1'b1;
                rnd_next    = '0;
                phase_next  = PH_FINAL;
                state_next  = ST_ROUND;
            end
            ST_OUT0:
            begin
                if (m_tready)
                begin
                    state_next = ST_OUT1;
                end
            end
            ST_OUT1:
            begin
                if (m_tready)
                begin
                    chain_next = init_chain();
                    count_next = '0;
                    last_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_DATA;
            last_reg  <= 1'b0;
            rnd_reg   <= '0;
            count_reg <= '0;
            chain_reg <= init_chain();
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            last_reg  <= last_next;
            rnd_reg   <= rnd_next;
            count_reg <= count_next;
            chain_reg <= chain_next;
        end
    end

    md5_blk_buf u_blk_buf (
        .clk       (clk),
        .ctrl      (bctl),
        .pos       (pos),
        .data_byte (s_tdata),
        .length    (count_reg),
        .rd_idx    (msg_idx),
        .rd_word   (msg_word)
    );

    md5_round u_round (
        .clk      (clk),
        .load     (load),
        .step     (step),
        .init     (chain_reg),
        .rnd      (rnd_reg),
        .msg_word (msg_word),
        .msg_idx  (msg_idx),
        .work     (work)
    );

    // Handshake and digest output.
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT0) || (state_reg == ST_OUT1);
    assign m_tuser  = (state_reg == ST_OUT1);
    assign m_tlast  = (state_reg == ST_OUT1);
    assign m_tdata  = (state_reg == ST_OUT1) ? {chain_reg.d, chain_reg.c}
                                             : {chain_reg.b, chain_reg.a};

endmodule

// ----- src/md5_core_chk.sv -----
// Port-level checker for the MD5 digest core, bound to the top level.
`include "assert_macros.svh"

module md5_core_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // The core never takes input while it offers a digest half.
    `ASSERT_NEVER(a_no_overlap, s_tready && m_tvalid, "input ready while digest is offered")

    // The second half follows the first without a gap.
    `ASSERT_CLK(a_second_half, m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser, "second digest half missing")

    // Only the second half carries the end mark.
    `ASSERT_CLK(a_last_is_second, m_tvalid |-> (m_tlast == m_tuser), "end mark on wrong half")

    // A stalled digest half holds its value.
    `ASSERT_CLK(a_hold, m_tvalid && !m_tready |=> $stable(m_tdata), "digest changed while stalled")

    // A final word starts padding or a compression, so the input closes at once.
    `ASSERT_CLK(a_busy_after_last, s_tvalid && s_tready && s_tlast |=> !s_tready, "input open after final word")

endmodule

bind md5_message_digest_core md5_core_chk u_md5_core_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
